// ===== rtl/plar_pkg.sv =====
// Shared types, codes and helpers of the priority layered LED region arbiter.
`timescale 1ns / 1ps
`default_nettype none

package plar_pkg;

  // Widest values the parameter ranges allow, used for the command word.
  localparam int APP_W_MAX   = 4;
  localparam int REG_W_MAX   = 5;
  localparam int COLOR_W_MAX = 32;
  localparam int CFG_IDX_W   = 1;

  typedef enum logic [1:0] {
    OP_SET  = 2'd0,
    OP_UPD  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESENT  = 1'b0,
    CFG_RESERVED = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    CMD_SET  = 2'd0,
    CMD_UPD  = 2'd1,
    CMD_READ = 2'd2,
    CMD_DONE = 2'd3
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  app;
    logic [7:0]  claim_mask;
    logic [3:0]  region;
    logic [23:0] color;
  } in_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  led_region;
    logic [23:0] led_color;
    logic [7:0]  granted_mask;
    logic [23:0] read_color;
    logic        error;
    logic        last;
  } out_t;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    cmd_kind_t               kind;
    logic                    err;
    logic                    ok;
    logic [APP_W_MAX-1:0]    app;
    logic [7:0]              claim;
    logic [REG_W_MAX-1:0]    ridx;
    logic [COLOR_W_MAX-1:0]  color;
  } cmd_t;

  // Bit of a region in the 8-bit masks; regions past 7 have no bit.
  function automatic logic [7:0] region_bit8(input logic [REG_W_MAX-1:0] q);
    logic [7:0] b;
    b = '0;
    for (int i = 0; i < 8; i++) begin
      b[i] = (q == REG_W_MAX'(i));
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/plar_ram.sv =====
// Generic single write port RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module plar_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/plar_fifo.sv =====
// Small register queue with push/full and pop/empty sides.
`timescale 1ns / 1ps
`default_nettype none

module plar_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2   // power of two, at least 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wp_r, wp_nxt;
  logic [PW-1:0]    rp_r, rp_nxt;
  logic [PW:0]      cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
    rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/plar_front.sv =====
// Front end: takes items, checks app and region, queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none

module plar_front #(
  parameter int NUM_APPS    = 4,
  parameter int NUM_REGIONS = 8,
  parameter int COLOR_BITS  = 24
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire plar_pkg::in_t    in_data,
  output logic                  in_full,
  input  wire logic [7:0]       reserved_mask,
  input  wire logic             clear_busy,
  output logic                  cmd_valid,
  input  wire logic             cmd_pop,
  output plar_pkg::cmd_t        cmd
);

  localparam int RMW = plar_pkg::REG_W_MAX;
  localparam int AMW = plar_pkg::APP_W_MAX;
  localparam int CMW = plar_pkg::COLOR_W_MAX;

  plar_pkg::cmd_t          cls;
  logic                    q_full, q_empty;
  logic [$bits(plar_pkg::cmd_t)-1:0] q_rdata;
  logic                    app_ok;
  logic [RMW-1:0]          upd_idx;

  always_comb begin
    app_ok  = (32'(in_data.app) < NUM_APPS);
    upd_idx = RMW'(in_data.region - 4'd1);
    cls       = '0;
    cls.app   = AMW'(in_data.app);
    cls.claim = in_data.claim_mask;
    cls.color = CMW'(COLOR_BITS'(in_data.color));
    case (plar_pkg::op_t'(in_data.op))
      plar_pkg::OP_SET: begin
        cls.kind = plar_pkg::CMD_SET;
      end
      plar_pkg::OP_UPD: begin
        // 1-based region; reserved regions are dropped here
        cls.kind = plar_pkg::CMD_UPD;
        cls.ridx = upd_idx;
        cls.ok   = (in_data.region != 4'd0) && (32'(in_data.region) <= NUM_REGIONS)
                   && !(|(plar_pkg::region_bit8(upd_idx) & reserved_mask));
      end
      plar_pkg::OP_READ: begin
        cls.kind = plar_pkg::CMD_READ;
        cls.ridx = RMW'(in_data.region);
        cls.ok   = (32'(in_data.region) < NUM_REGIONS);
      end
      default: begin
        cls.kind = plar_pkg::CMD_DONE;
      end
    endcase
    if ((plar_pkg::op_t'(in_data.op) != plar_pkg::OP_NOP) && !app_ok) begin
      cls.kind = plar_pkg::CMD_DONE;
      cls.err  = 1'b1;
    end
  end

  plar_fifo #(
    .WIDTH($bits(plar_pkg::cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !in_full),
    .wdata (cls),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  assign in_full   = q_full || clear_busy;
  assign cmd_valid = !q_empty;
  assign cmd       = plar_pkg::cmd_t'(q_rdata);

endmodule

`default_nettype wire

// ===== rtl/plar_back.sv =====
// Back end: claim masks, color cache and the sequencer that emits drives and completions.
`timescale 1ns / 1ps
`default_nettype none

module plar_back #(
  parameter int NUM_APPS    = 4,
  parameter int NUM_REGIONS = 8,
  parameter int COLOR_BITS  = 24
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [7:0]     present_mask,
  input  wire logic [7:0]     reserved_mask,
  input  wire logic           cmd_valid,
  input  wire plar_pkg::cmd_t cmd,
  output logic                cmd_pop,
  input  wire logic           res_full,
  output logic                res_push,
  output plar_pkg::out_t      res_data,
  output logic                clear_busy
);

  localparam int AW    = $clog2(NUM_APPS);
  localparam int RW    = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int DEPTH = NUM_APPS << RW;
  localparam int MW    = AW + RW;
  localparam int RMW   = plar_pkg::REG_W_MAX;

  typedef enum logic [6:0] {
    ST_CLEAR     = 7'b0000001,
    ST_IDLE      = 7'b0000010,
    ST_SET_SCAN  = 7'b0000100,
    ST_SET_DRIVE = 7'b0001000,
    ST_UPD_DRIVE = 7'b0010000,
    ST_RD_WAIT   = 7'b0100000,
    ST_DONE      = 7'b1000000
  } state_t;

  // Highest app claiming region q, app 0 when nobody does.
  function automatic logic [AW-1:0] owner_of(input logic [NUM_APPS-1:0][7:0] cl,
                                             input logic [RW-1:0] q);
    logic [AW-1:0] o;
    logic [7:0]    b;
    o = '0;
    b = plar_pkg::region_bit8(RMW'(q));
    for (int k = 1; k < NUM_APPS; k++) begin
      if (|(cl[k] & b)) begin
        o = AW'(k);
      end
    end
    return o;
  endfunction

  state_t                     state_r, state_nxt;
  logic [MW-1:0]              clr_addr_r, clr_addr_nxt;
  logic [NUM_APPS-1:0][7:0]   claims_r, claims_nxt;
  plar_pkg::cmd_t             cmd_r, cmd_nxt;
  logic [RW-1:0]              r_r, r_nxt;
  logic [7:0]                 changed_r, changed_nxt;
  logic [7:0]                 granted_r, granted_nxt;
  logic [COLOR_BITS-1:0]      rcolor_r, rcolor_nxt;
  logic                       err_r, err_nxt;

  logic                       ram_we, ram_re;
  logic [MW-1:0]              ram_waddr, ram_raddr;
  logic [COLOR_BITS-1:0]      ram_wdata, ram_rdata;

  logic [AW-1:0]              h_app, c_app, scan_own;
  logic [RW-1:0]              h_r;
  logic [7:0]                 h_bit, scan_bit;
  logic                       scan_last;

  assign h_app     = AW'(cmd.app);
  assign h_r       = RW'(cmd.ridx);
  assign h_bit     = plar_pkg::region_bit8(RMW'(h_r));
  assign c_app     = AW'(cmd_r.app);
  assign scan_own  = owner_of(claims_r, r_r);
  assign scan_bit  = plar_pkg::region_bit8(RMW'(r_r));
  assign scan_last = (r_r == RW'(NUM_REGIONS - 1));
  assign clear_busy = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    claims_nxt   = claims_r;
    cmd_nxt      = cmd_r;
    r_nxt        = r_r;
    changed_nxt  = changed_r;
    granted_nxt  = granted_r;
    rcolor_nxt   = rcolor_r;
    err_nxt      = err_r;
    cmd_pop      = 1'b0;
    res_push     = 1'b0;
    res_data     = '0;
    ram_we       = 1'b0;
    ram_waddr    = {h_app, h_r};
    ram_wdata    = COLOR_BITS'(cmd.color);
    ram_re       = 1'b0;
    ram_raddr    = {h_app, h_r};

    case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        ram_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == MW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop     = 1'b1;
          cmd_nxt     = cmd;
          r_nxt       = h_r;
          granted_nxt = '0;
          rcolor_nxt  = '0;
          err_nxt     = cmd.err;
          state_nxt   = ST_DONE;
          case (cmd.kind)
            plar_pkg::CMD_SET: begin
              changed_nxt       = claims_r[h_app] ^ cmd.claim;
              claims_nxt[h_app] = cmd.claim;
              r_nxt             = '0;
              state_nxt         = ST_SET_SCAN;
            end
            plar_pkg::CMD_UPD: begin
              if (cmd.ok) begin
                ram_we = 1'b1;
                if ((owner_of(claims_r, h_r) == h_app) && |(h_bit & present_mask)) begin
                  state_nxt = ST_UPD_DRIVE;
                end
              end
            end
            plar_pkg::CMD_READ: begin
              if (cmd.ok) begin
                ram_re    = 1'b1;
                state_nxt = ST_RD_WAIT;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SET_SCAN: begin
        // claims already hold the new mask, so owners are post-update
        if (scan_own <= c_app) begin
          if (scan_own == c_app) begin
            granted_nxt = granted_r | (cmd_r.claim & scan_bit);
          end
        end
        if ((scan_own <= c_app) &&
            |(changed_r & scan_bit & present_mask & ~reserved_mask)) begin
          ram_re    = 1'b1;
          ram_raddr = {scan_own, r_r};
          state_nxt = ST_SET_DRIVE;
        end else if (scan_last) begin
          state_nxt = ST_DONE;
        end else begin
          r_nxt = r_r + 1'b1;
        end
      end

      ST_SET_DRIVE: begin
        if (!res_full) begin
          res_push            = 1'b1;
          res_data.led_region = 3'(r_r);
          res_data.led_color  = 24'(ram_rdata);
          if (scan_last) begin
            state_nxt = ST_DONE;
          end else begin
            r_nxt     = r_r + 1'b1;
            state_nxt = ST_SET_SCAN;
          end
        end
      end

      ST_UPD_DRIVE: begin
        if (!res_full) begin
          res_push            = 1'b1;
          res_data.led_region = 3'(r_r);
          res_data.led_color  = 24'(COLOR_BITS'(cmd_r.color));
          granted_nxt         = scan_bit;
          state_nxt           = ST_DONE;
        end
      end

      ST_RD_WAIT: begin
        rcolor_nxt = ram_rdata;
        state_nxt  = ST_DONE;
      end

      ST_DONE: begin
        if (!res_full) begin
          res_push              = 1'b1;
          res_data.kind         = 1'b1;
          res_data.granted_mask = granted_r;
          res_data.read_color   = 24'(rcolor_r);
          res_data.error        = err_r;
          res_data.last         = 1'b1;
          state_nxt             = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      claims_r   <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      claims_r   <= claims_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    r_r       <= r_nxt;
    changed_r <= changed_nxt;
    granted_r <= granted_nxt;
    rcolor_r  <= rcolor_nxt;
    err_r     <= err_nxt;
  end

  plar_ram #(
    .WIDTH(COLOR_BITS),
    .DEPTH(DEPTH)
  ) u_color_cache (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// ===== rtl/priority_layered_led_region_arbiter_core.sv =====
// Top level of the priority layered LED region arbiter.
//
// Input queue side: drive in_data and raise in_push; the item is taken on a
// clock edge where in_full is low. Ops: set control claims, update a region
// color, read a cached color. Result queue side: while out_empty is low the
// oldest result sits on out_data; pop it with out_pop. Each item yields zero
// or more LED drives (kind 0) followed by one completion (kind 1, last 1).
// cfg_we writes the region present mask (index 0) or the reserved region mask
// (index 1); write only while the block is idle.
// The back end takes one item at a time. A set control scans every region
// and reads the cache once per LED drive; an update that passes its checks
// writes the cache and drives the region when the app owns it and it is
// present; a read waits for the cache read unless the index is out of range.
// A bad app or an unused op yields only its completion.
// Two-entry queues sit between front and back end and before the result port.
// Reset: claims and config clear at once, then a clearing pass zeroes all
// NUM_APPS * 2^max(1, ceil(log2(NUM_REGIONS))) color cache entries (32 by
// default) while in_full stays high. A stalled receiver holds the back end
// with its result pending; in_full rises once the command queue fills.
`timescale 1ns / 1ps
`default_nettype none

module priority_layered_led_region_arbiter_core #(
  parameter int NUM_APPS    = 4,   // 2..16
  parameter int NUM_REGIONS = 8,   // 1..32
  parameter int COLOR_BITS  = 24   // 1..32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_push,
  input  wire plar_pkg::in_t                       in_data,
  output logic                                     in_full,
  output logic                                     out_empty,
  input  wire logic                                out_pop,
  output plar_pkg::out_t                           out_data,
  input  wire logic                                cfg_we,
  input  wire logic [plar_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [7:0]                          cfg_wdata
);

  logic [7:0]       present_r, reserved_r;
  logic             clear_busy;
  logic             cmd_valid, cmd_pop;
  plar_pkg::cmd_t   cmd;
  logic             res_full, res_push;
  plar_pkg::out_t   res_data;
  logic [$bits(plar_pkg::out_t)-1:0] res_rdata;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r  <= '0;
      reserved_r <= '0;
    end else if (cfg_we) begin
      case (plar_pkg::cfg_idx_t'(cfg_index))
        plar_pkg::CFG_PRESENT:  present_r  <= cfg_wdata;
        plar_pkg::CFG_RESERVED: reserved_r <= cfg_wdata;
        default: begin
          present_r <= present_r;
        end
      endcase
    end
  end

  plar_front #(
    .NUM_APPS    (NUM_APPS),
    .NUM_REGIONS (NUM_REGIONS),
    .COLOR_BITS  (COLOR_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_data       (in_data),
    .in_full       (in_full),
    .reserved_mask (reserved_r),
    .clear_busy    (clear_busy),
    .cmd_valid     (cmd_valid),
    .cmd_pop       (cmd_pop),
    .cmd           (cmd)
  );

  plar_back #(
    .NUM_APPS    (NUM_APPS),
    .NUM_REGIONS (NUM_REGIONS),
    .COLOR_BITS  (COLOR_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .present_mask  (present_r),
    .reserved_mask (reserved_r),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .res_full      (res_full),
    .res_push      (res_push),
    .res_data      (res_data),
    .clear_busy    (clear_busy)
  );

  // result queue toward the receiver
  plar_fifo #(
    .WIDTH($bits(plar_pkg::out_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_data = plar_pkg::out_t'(res_rdata);

endmodule

`default_nettype wire

// ===== tb/tb_priority_layered_led_region_arbiter_core.sv =====
// Self-checking testbench of the priority layered LED region arbiter core.
`timescale 1ns / 1ps

module tb_priority_layered_led_region_arbiter_core;

  localparam int NUM_APPS     = 4;
  localparam int NUM_REGIONS  = 8;
  localparam int COLOR_BITS   = 24;
  localparam int IDLE_PCT     = 21;      // idle / stall odds per cycle, in percent
  localparam int SETTLE_CYCLES = 20;     // quiet time after the last result
  localparam int CYCLE_LIMIT  = 300000;  // hard stop, far above the slowest run
  localparam int MAX_REPORTS  = 40;      // cap on printed error lines
  localparam int PHASE_ITEMS  = 73;      // random items per config setting

  // Result kinds.
  localparam logic KIND_DRIVE = 1'b0;
  localparam logic KIND_DONE  = 1'b1;

  // Predicts the result stream of the arbiter and checks what comes out.
  class led_arbiter_scoreboard;
    logic [23:0]      color_cache [NUM_APPS][NUM_REGIONS];
    logic [7:0]       claims [NUM_APPS];
    logic [7:0]       present;
    logic [7:0]       reserved;
    plar_pkg::out_t   expected_q [$];
    int               errors;

    function new();
      foreach (color_cache[a, r]) color_cache[a][r] = '0;
      foreach (claims[a]) claims[a] = '0;
      present  = '0;
      reserved = '0;
      errors   = 0;
    endfunction

    task report_error(string msg);
      if (errors < MAX_REPORTS) $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    function int pending();
      return expected_q.size();
    endfunction

    function void set_register(plar_pkg::cfg_idx_t idx, logic [7:0] value);
      if (idx == plar_pkg::CFG_PRESENT) present = value;
      else reserved = value;
    endfunction

    // Highest app claiming the region; app 0 owns it by default.
    function int region_owner(int r);
      for (int a = NUM_APPS - 1; a > 0; a--) begin
        if (claims[a][r]) return a;
      end
      return 0;
    endfunction

    function void add_result(logic kind, logic [2:0] led_region, logic [23:0] led_color,
                             logic [7:0] granted, logic [23:0] read_color,
                             logic err, logic last);
      plar_pkg::out_t r;
      r.kind         = kind;
      r.led_region   = led_region;
      r.led_color    = led_color;
      r.granted_mask = granted;
      r.read_color   = read_color;
      r.error        = err;
      r.last         = last;
      expected_q.push_back(r);
    endfunction

    // Works out every result that an accepted item causes.
    function void note_item(plar_pkg::in_t it);
      int          a;
      int          r;
      int          own;
      logic [7:0]  changed;
      logic [7:0]  granted;
      logic [23:0] rc;
      granted = '0;
      rc      = '0;
      a       = it.app;
      if (plar_pkg::op_t'(it.op) == plar_pkg::OP_NOP) begin
        add_result(KIND_DONE, '0, '0, '0, '0, 1'b0, 1'b1);
        return;
      end
      if (it.app >= NUM_APPS) begin
        add_result(KIND_DONE, '0, '0, '0, '0, 1'b1, 1'b1);
        return;
      end
      case (plar_pkg::op_t'(it.op))
        plar_pkg::OP_SET: begin
          changed   = claims[a] ^ it.claim_mask;
          claims[a] = it.claim_mask;
          for (r = 0; r < NUM_REGIONS; r++) begin
            own = region_owner(r);
            if (own > a) continue;  // shadowed by a higher app
            if (own == a) granted[r] = it.claim_mask[r];
            if (changed[r] && present[r] && !reserved[r])
              add_result(KIND_DRIVE, 3'(r), color_cache[own][r], '0, '0, 1'b0, 1'b0);
          end
          add_result(KIND_DONE, '0, '0, granted, '0, 1'b0, 1'b1);
        end
        plar_pkg::OP_UPD: begin
          if (it.region >= 1 && it.region <= NUM_REGIONS) begin
            r = it.region - 1;
            if (!reserved[r]) begin
              color_cache[a][r] = it.color;
              if (region_owner(r) == a && present[r]) begin
                add_result(KIND_DRIVE, 3'(r), it.color, '0, '0, 1'b0, 1'b0);
                granted[r] = 1'b1;
              end
            end
          end
          add_result(KIND_DONE, '0, '0, granted, '0, 1'b0, 1'b1);
        end
        plar_pkg::OP_READ: begin
          if (it.region < NUM_REGIONS) rc = color_cache[a][it.region];
          add_result(KIND_DONE, '0, '0, '0, rc, 1'b0, 1'b1);
        end
        default: ;
      endcase
    endfunction

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_error($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task check_result(plar_pkg::out_t got);
      plar_pkg::out_t want;
      if (expected_q.size() == 0) begin
        report_error($sformatf("result %0h with nothing expected", got));
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind",         got.kind,         want.kind);
      compare_field("led_region",   got.led_region,   want.led_region);
      compare_field("led_color",    got.led_color,    want.led_color);
      compare_field("granted_mask", got.granted_mask, want.granted_mask);
      compare_field("read_color",   got.read_color,   want.read_color);
      compare_field("error",        got.error,        want.error);
      compare_field("last",         got.last,         want.last);
    endtask
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_push;
  plar_pkg::in_t      in_data;
  logic               in_full;
  logic               out_empty;
  logic               out_pop;
  plar_pkg::out_t     out_data;
  logic               cfg_we;
  plar_pkg::cfg_idx_t cfg_index;
  logic [7:0]         cfg_wdata;

  // When set, neither side idles: the run goes at full rate.
  bit calm = 1'b0;
  int cycle_count = 0;

  led_arbiter_scoreboard sb = new();

  priority_layered_led_region_arbiter_core #(
    .NUM_APPS    (NUM_APPS),
    .NUM_REGIONS (NUM_REGIONS),
    .COLOR_BITS  (COLOR_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Result side: values are sampled right after the edge, so they are the
  // ones the DUT presented at that edge. Pop stalls at random unless calm.
  initial begin
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) sb.check_result(out_data);
      out_pop <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic plar_pkg::in_t make_item(plar_pkg::op_t op, int app, int claim,
                                              int region, int color);
    plar_pkg::in_t it;
    it.op         = op;
    it.app        = 3'(app);
    it.claim_mask = 8'(claim);
    it.region     = 4'(region);
    it.color      = 24'(color);
    return it;
  endfunction

  // Mostly valid apps and in-range regions, with a share of bad ones.
  function automatic plar_pkg::in_t random_item();
    plar_pkg::in_t it;
    int unsigned   pick;
    pick          = $urandom_range(99);
    it.claim_mask = 8'($urandom);
    it.color      = 24'($urandom);
    it.app        = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 4))
                                             : 3'($urandom_range(NUM_APPS - 1));
    if (pick < 30) it.op = plar_pkg::OP_SET;
    else if (pick < 70) it.op = plar_pkg::OP_UPD;
    else if (pick < 93) it.op = plar_pkg::OP_READ;
    else it.op = plar_pkg::OP_NOP;
    case ($urandom_range(9))
      0: it.claim_mask = 8'h00;
      1: it.claim_mask = 8'hFF;
      default: ;
    endcase
    case ($urandom_range(9))
      0: it.color = 24'h000000;
      1: it.color = 24'hFFFFFF;
      default: ;
    endcase
    if (plar_pkg::op_t'(it.op) == plar_pkg::OP_UPD) begin
      if ($urandom_range(9) == 0)
        it.region = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, NUM_REGIONS + 1));
      else
        it.region = 4'($urandom_range(NUM_REGIONS, 1));
    end else begin
      it.region = ($urandom_range(99) < 15) ? 4'($urandom_range(15, NUM_REGIONS))
                                            : 4'($urandom_range(NUM_REGIONS - 1));
    end
    return it;
  endfunction

  // Push stays high from one item to the next unless an idle cycle falls
  // between them, so it never gets two assignments in one step.
  task automatic send_item(input plar_pkg::in_t it);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    sb.note_item(it);
  endtask

  // Stop sending and wait until every expected result has been popped.
  task automatic wait_until_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Both registers, back to back; only called while the block is idle.
  task automatic load_config(logic [7:0] present, logic [7:0] reserved);
    cfg_we    <= 1'b1;
    cfg_index <= plar_pkg::CFG_PRESENT;
    cfg_wdata <= present;
    @(posedge clk);
    cfg_index <= plar_pkg::CFG_RESERVED;
    cfg_wdata <= reserved;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_register(plar_pkg::CFG_PRESENT, present);
    sb.set_register(plar_pkg::CFG_RESERVED, reserved);
  endtask

  initial begin
    logic [7:0] present_set  [6];
    logic [7:0] reserved_set [6];

    rst_n     <= 1'b0;
    in_push   <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= plar_pkg::CFG_PRESENT;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // The cache clearing pass holds in_full high; wait it out.
    do @(posedge clk); while (in_full);

    // Directed part: every region driven, first and last region reserved.
    load_config(8'hFF, 8'h81);
    send_item(make_item(plar_pkg::OP_UPD, 0, 0, 1, 'hFFFFFF));   // reserved region, ignored
    send_item(make_item(plar_pkg::OP_UPD, 0, 0, 2, 'h123456));   // app 0 owns by default
    send_item(make_item(plar_pkg::OP_UPD, 1, 0, 2, 'hFFFFFF));   // cached, not owner
    send_item(make_item(plar_pkg::OP_UPD, 3, 0, 8, 'h000000));   // last region, reserved
    send_item(make_item(plar_pkg::OP_UPD, 2, 0, 0, 'hABCDEF));   // region 0 is invalid
    send_item(make_item(plar_pkg::OP_UPD, 2, 0, 9, 'h654321));   // past the last region
    send_item(make_item(plar_pkg::OP_UPD, 2, 0, 15, 'hFFFFFF));
    send_item(make_item(plar_pkg::OP_UPD, 3, 0, 5, 'h000000));
    send_item(make_item(plar_pkg::OP_SET, 1, 'hFF, 0, 0));       // app 1 takes everything
    send_item(make_item(plar_pkg::OP_SET, 3, 'h0F, 15, 'hFFFFFF));
    send_item(make_item(plar_pkg::OP_SET, 0, 'hFF, 0, 0));       // shadowed by apps 1 and 3
    send_item(make_item(plar_pkg::OP_SET, 1, 'h00, 0, 0));
    send_item(make_item(plar_pkg::OP_SET, 3, 'h00, 0, 0));
    send_item(make_item(plar_pkg::OP_READ, 1, 0, 1, 0));
    send_item(make_item(plar_pkg::OP_READ, 3, 'hFF, 7, 'hFFFFFF));
    send_item(make_item(plar_pkg::OP_READ, 0, 0, 8, 0));         // index past the regions
    send_item(make_item(plar_pkg::OP_READ, 2, 0, 15, 0));
    send_item(make_item(plar_pkg::OP_SET, 4, 'hFF, 0, 0));       // bad app on each op
    send_item(make_item(plar_pkg::OP_UPD, 7, 0, 3, 'hFFFFFF));
    send_item(make_item(plar_pkg::OP_READ, 5, 0, 2, 0));
    send_item(make_item(plar_pkg::OP_NOP, 6, 'hAA, 15, 'hFFFFFF));
    send_item(make_item(plar_pkg::OP_NOP, 0, 0, 0, 0));
    send_item(make_item(plar_pkg::OP_UPD, 2, 0, 4, 'hFFFFFF));
    send_item(make_item(plar_pkg::OP_SET, 2, 'hFF, 0, 0));
    wait_until_drained();

    // Random part, one config setting per phase, extremes among them.
    present_set  = '{8'hFF, 8'h00, 8'hFF, 8'($urandom), 8'hFF, 8'($urandom)};
    reserved_set = '{8'h00, 8'h00, 8'hFF, 8'($urandom), 8'h00,
                     8'($urandom) & 8'($urandom)};
    for (int ph = 0; ph < 6; ph++) begin
      load_config(present_set[ph], reserved_set[ph]);
      calm = (ph == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Mid-phase, hold off until the result queue has fully drained.
        if (ph == 3 && n == PHASE_ITEMS / 2) wait_until_drained();
        send_item(random_item());
      end
      wait_until_drained();
      calm = 1'b0;
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/plar_pkg.sv
rtl/plar_ram.sv
rtl/plar_fifo.sv
rtl/plar_front.sv
rtl/plar_back.sv
rtl/priority_layered_led_region_arbiter_core.sv
tb/tb_priority_layered_led_region_arbiter_core.sv
